FILE: hdl/lsc_pkg.sv
// Shared types, codes and constants of the layered sprite compositor.
package lsc_pkg;

  localparam int BoardRowsDef = 64;
  localparam int BoardColsDef = 64;
  localparam int NameCharsDef = 8;

  localparam logic [7:0] EmptyChar = 8'd46;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] layer_depth;
    logic [63:0]        layer_key;
    logic [5:0]         origin_row;
    logic [5:0]         origin_col;
    logic [5:0]         local_row;
    logic [5:0]         local_col;
    logic [7:0]         pixel_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] board_char;
    logic [6:0] rows_used;
    logic [6:0] cols_used;
    logic       off_board;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hdl/layered_sprite_compositor.sv
// Top level of the layered sprite compositor: per-pixel depth buffer board.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_stall_o   in_data_i  (lsc_pkg::in_item_t)
//   out       out  out_valid_o/out_stall_i out_data_o (lsc_pkg::out_item_t)
//
// Write and read items load with a RAM read, then read-modify-write in the response state.
// A clear item sweeps all BOARD_ROWS*BOARD_COLS RAM entries, one RAM entry swept per cycle.
// After reset the same sweep runs before the first item.
// A stalled output holds the response stage; one finished item waits in the output register.
module layered_sprite_compositor #(
  parameter int BOARD_ROWS = lsc_pkg::BoardRowsDef,
  parameter int BOARD_COLS = lsc_pkg::BoardColsDef,
  parameter int NAME_CHARS = lsc_pkg::NameCharsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lsc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsc_pkg::out_item_t out_data_o
);
  import lsc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  lsc_datapath #(
    .BOARD_ROWS (BOARD_ROWS),
    .BOARD_COLS (BOARD_COLS),
    .NAME_CHARS (NAME_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/lsc_ram.sv
// Generic simple dual-port RAM with registered read.
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lsc_datapath.sv
// Datapath: address calc, depth buffer RAM, depth/key compare, extents, output register.
module lsc_datapath #(
  parameter int BOARD_ROWS = lsc_pkg::BoardRowsDef,
  parameter int BOARD_COLS = lsc_pkg::BoardColsDef,
  parameter int NAME_CHARS = lsc_pkg::NameCharsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsc_pkg::in_item_t  in_data_i,
  input  lsc_pkg::ctrl_cmd_t cmd_i,
  output lsc_pkg::dp_status_t status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsc_pkg::out_item_t out_data_o
);
  import lsc_pkg::*;

  localparam int Cells = BOARD_ROWS * BOARD_COLS;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int KW    = 8 * NAME_CHARS;
  localparam int EW    = 1 + 16 + KW + 8;

  // accept-time address calculation
  logic [6:0]  row_in, col_in;
  logic        onb_in;
  logic [31:0] addr_full;

  always_comb begin
    if (in_data_i.kind == KIND_READ) begin
      row_in = {1'b0, in_data_i.local_row};
      col_in = {1'b0, in_data_i.local_col};
    end else begin
      row_in = {1'b0, in_data_i.origin_row} + {1'b0, in_data_i.local_row};
      col_in = {1'b0, in_data_i.origin_col} + {1'b0, in_data_i.local_col};
    end
    onb_in    = (32'(row_in) < 32'(BOARD_ROWS)) && (32'(col_in) < 32'(BOARD_COLS));
    addr_full = 32'(row_in) * 32'(BOARD_COLS) + 32'(col_in);
  end

  logic [1:0]         kind_q;
  logic signed [15:0] depth_q;
  logic [KW-1:0]      key_q;
  logic [7:0]         char_q;
  logic [6:0]         row_q, col_q;
  logic               onb_q;
  logic [AW-1:0]      addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_data_i.kind;
      depth_q <= in_data_i.layer_depth;
      key_q   <= in_data_i.layer_key[63 -: KW];
      char_q  <= in_data_i.pixel_char;
      row_q   <= row_in;
      col_q   <= col_in;
      onb_q   <= onb_in;
      addr_q  <= addr_full[AW-1:0];
    end
  end

  // depth buffer: {painted, depth, key, char}
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;
  logic [AW-1:0]      cnt_q, cnt_d;

  lsc_ram #(
    .WIDTH (EW),
    .DEPTH (Cells),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (addr_full[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  logic               old_painted;
  logic signed [15:0] old_depth;
  logic [KW-1:0]      old_key;
  logic [7:0]         old_char;
  logic               win, do_write;
  logic [7:0]         bchar;
  logic [6:0]         rext_q, rext_d, cext_q, cext_d;
  logic [6:0]         row_p1, col_p1;

  always_comb begin
    old_painted = ram_rdata[EW-1];
    old_depth   = ram_rdata[EW-2 -: 16];
    old_key     = ram_rdata[8 +: KW];
    old_char    = ram_rdata[7:0];
    win = !old_painted || (depth_q < old_depth) ||
          ((depth_q == old_depth) && (key_q >= old_key));
    do_write = (kind_q == KIND_WRITE) && onb_q && (char_q != EmptyChar) && win;
    case (kind_q)
      KIND_WRITE: begin
        if (!onb_q)        bchar = EmptyChar;
        else if (do_write) bchar = char_q;
        else if (old_painted) bchar = old_char;
        else               bchar = EmptyChar;
      end
      KIND_READ: bchar = (onb_q && old_painted) ? old_char : EmptyChar;
      default:   bchar = EmptyChar;
    endcase
  end

  assign ram_we    = cmd_i.sweep || (cmd_i.fire && do_write);
  assign ram_waddr = cmd_i.sweep ? cnt_q : addr_q;
  assign ram_wdata = cmd_i.sweep ? '0 : {1'b1, depth_q, key_q, char_q};

  // extents
  assign row_p1 = row_q + 7'd1;
  assign col_p1 = col_q + 7'd1;

  always_comb begin
    rext_d = rext_q;
    cext_d = cext_q;
    if (cmd_i.load && (in_data_i.kind == KIND_CLEAR)) begin
      rext_d = '0;
      cext_d = '0;
    end else if (cmd_i.fire && (kind_q == KIND_WRITE) && onb_q) begin
      if (row_p1 > rext_q) rext_d = row_p1;
      if (col_p1 > cext_q) cext_d = col_p1;
    end
  end

  // sweep counter
  assign status_o.sweep_last = (cnt_q == AW'(Cells - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.sweep) begin
      cnt_d = status_o.sweep_last ? '0 : cnt_q + AW'(1);
    end
  end

  logic out_valid_q, out_valid_d;
  out_item_t out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.fire) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rext_q      <= '0;
      cext_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rext_q      <= rext_d;
      cext_q      <= cext_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      out_q.board_char <= bchar;
      out_q.rows_used  <= rext_d;
      out_q.cols_used  <= cext_d;
      out_q.off_board  <= (kind_q == KIND_WRITE) && !onb_q;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  a_off_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.off_board |-> out_data_o.board_char == EmptyChar)
    else $error("dropped pixel reports a character");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && cmd_i.load))
    else $error("RAM write during item load");

  a_clear_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && (kind_q == KIND_CLEAR) |=>
      (out_data_o.rows_used == '0) && (out_data_o.cols_used == '0))
    else $error("clear item left extents set");

  a_extent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.rows_used) <= 32'(BOARD_ROWS)) &&
                    (32'(out_data_o.cols_used) <= 32'(BOARD_COLS)))
    else $error("extent beyond board");

endmodule

FILE: hdl/lsc_ctrl.sv
// Controller state machine: init sweep, item load, clear sweep, response.
module lsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  input  lsc_pkg::dp_status_t status_i,
  output logic                in_stall_o,
  output lsc_pkg::ctrl_cmd_t  cmd_o
);
  import lsc_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == KIND_CLEAR) ? ST_CLEAR : ST_RESP;
        end
      end
      ST_CLEAR: begin
        if (status_i.sweep_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sweep = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.fire  = (state_q == ST_RESP) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
